// ===== src/sequence_range_reorder_tracker_assert.svh =====
// Assertion macros for the range tracker checker
`ifndef SEQUENCE_RANGE_REORDER_TRACKER_ASSERT_SVH
`define SEQUENCE_RANGE_REORDER_TRACKER_ASSERT_SVH

// same-cycle implication
`define SRRT_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRRT_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/srrt_pkg.sv =====
package srrt_pkg;

    localparam int DEF_MAX_RANGES = 16;
    localparam int DEF_SEQ_BITS   = 16;

    localparam int FIELD_W    = 16;
    localparam int OFF_W      = 8;
    localparam int PKT_W      = 17;
    localparam int BYTE_W     = 32;
    localparam int CNT_OUT_W  = 5;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USED_W = BYTE_W + CNT_OUT_W + 2 * FIELD_W;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DECIDE,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic dup;
        logic above;
        logic adj_below;
        logic adj_above;
    } t_cmp_res;

endpackage

// ===== src/srrt_cmp.sv =====
module srrt_cmp #(
    parameter int SEQ_BITS = 16
) (
    input  logic [SEQ_BITS-1:0]   i_seq,
    input  logic [2*SEQ_BITS-1:0] i_entry,
    output srrt_pkg::t_cmp_res    o_res
);
    import srrt_pkg::*;

    logic [SEQ_BITS:0] w_seq;
    logic [SEQ_BITS:0] w_low;
    logic [SEQ_BITS:0] w_high;

    assign w_seq  = {1'b0, i_seq};
    assign w_low  = {1'b0, i_entry[2*SEQ_BITS-1:SEQ_BITS]};
    assign w_high = {1'b0, i_entry[SEQ_BITS-1:0]};

    // no wrap: one spare bit on every side of the compare
    assign o_res.dup       = (w_seq >= w_low) && (w_seq <= w_high);
    assign o_res.above     = w_seq > w_high;
    assign o_res.adj_below = w_seq == (w_high + (SEQ_BITS + 1)'(1));
    assign o_res.adj_above = (w_seq + (SEQ_BITS + 1)'(1)) == w_low;

endmodule

// ===== src/srrt_mem.sv =====
module srrt_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sequence_range_reorder_tracker.sv =====
// channel  | dir | tdata (lsb first)                                  | tuser
// s_axis   | in  | sequence_number, first_entry_bytes, rest_bytes,    | action
//          |     | header_offset                                      |
// m_axis   | out | bytes_received, range_count, first_range_low,      | status
//          |     | first_range_high, 3 zero bits                      |
//
// Reads of the range memory are registered: every compare and every move waits
// for its read data, so the time a transfer takes grows with the ranges walked
// past and with the entries moved to open or close a slot.
// Reset clears control, range count and byte total; the memory is not cleared.
// A finished result waits in the output register; the next transfer is taken
// as soon as the sequencer is idle, and it stalls only at its end if m_axis is
// still full.
module sequence_range_reorder_tracker #(
    parameter int MAX_RANGES = srrt_pkg::DEF_MAX_RANGES,
    parameter int SEQ_BITS   = srrt_pkg::DEF_SEQ_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sequence_number, first_entry_bytes, rest_bytes, header_offset
    input  logic [srrt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // action
    input  logic [0:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // bytes_received, range_count, first_range_low, first_range_high
    output logic [srrt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic [1:0]                       o_m_axis_tuser
);
    import srrt_pkg::*;

    localparam int AW = $clog2(MAX_RANGES);
    localparam int IW = $clog2(MAX_RANGES + 1);
    localparam int EW = 2 * SEQ_BITS;
    localparam logic [IW-1:0] MAX_CNT = IW'(MAX_RANGES);

    t_state              r_state, n_state;
    logic [SEQ_BITS-1:0] r_seq, n_seq;
    logic [PKT_W-1:0]    r_pkt, n_pkt;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_count, n_count;
    logic [IW-1:0]       r_shift, n_shift;
    logic [BYTE_W-1:0]   r_total, n_total;
    logic [EW-1:0]       r_prev, n_prev;
    logic                r_prev_adj, n_prev_adj;
    logic [EW-1:0]       r_cur, n_cur;
    logic                r_cur_adj, n_cur_adj;
    t_status             r_status, n_status;
    logic [EW-1:0]       r_first;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [EW-1:0]       mem_wr_data;
    logic                mem_rd_en;
    logic [AW-1:0]       mem_rd_addr;
    logic [EW-1:0]       mem_rd_data;
    t_cmp_res            w_cmp;

    logic [FIELD_W+SEQ_BITS-1:0] w_seq_ext;
    logic [SEQ_BITS-1:0]         w_seq;
    logic [FIELD_W-1:0]          w_first_bytes;
    logic [FIELD_W-1:0]          w_rest_bytes;
    logic [FIELD_W-1:0]          w_off;
    logic [FIELD_W-1:0]          w_off_cl;
    logic [PKT_W-1:0]            w_pkt;
    logic [BYTE_W:0]             w_sum;
    logic [BYTE_W-1:0]           w_total_sat;
    logic [IW-1:0]               w_idx_m1;
    logic [IW-1:0]               w_shift_m1;
    logic [IW-1:0]               w_shift_p1;
    logic                        w_have_prev;
    logic                        w_have_cur;
    logic [IW+CNT_OUT_W-1:0]     w_cnt_ext;
    logic [SEQ_BITS+FIELD_W-1:0] w_low_ext;
    logic [SEQ_BITS+FIELD_W-1:0] w_high_ext;
    logic [FIELD_W-1:0]          w_out_low;
    logic [FIELD_W-1:0]          w_out_high;

    // input unpack and per-packet byte count
    assign w_seq_ext     = {{SEQ_BITS{1'b0}}, i_s_axis_tdata[FIELD_W-1:0]};
    assign w_seq         = w_seq_ext[SEQ_BITS-1:0];
    assign w_first_bytes = i_s_axis_tdata[2*FIELD_W-1:FIELD_W];
    assign w_rest_bytes  = i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
    assign w_off         = {{(FIELD_W-OFF_W){1'b0}}, i_s_axis_tdata[3*FIELD_W+OFF_W-1:3*FIELD_W]};
    assign w_off_cl      = (w_off > w_first_bytes) ? w_first_bytes : w_off;
    assign w_pkt         = {1'b0, w_first_bytes - w_off_cl} + {1'b0, w_rest_bytes};

    // saturating accumulate
    assign w_sum       = {1'b0, r_total} + {{(BYTE_W+1-PKT_W){1'b0}}, r_pkt};
    assign w_total_sat = w_sum[BYTE_W] ? {BYTE_W{1'b1}} : w_sum[BYTE_W-1:0];

    assign w_idx_m1    = r_idx - IW'(1);
    assign w_shift_m1  = r_shift - IW'(1);
    assign w_shift_p1  = r_shift + IW'(1);
    assign w_have_prev = r_idx != '0;
    assign w_have_cur  = r_idx < r_count;

    // result pack
    assign w_cnt_ext  = {{CNT_OUT_W{1'b0}}, r_count};
    assign w_low_ext  = {{FIELD_W{1'b0}}, r_first[EW-1:SEQ_BITS]};
    assign w_high_ext = {{FIELD_W{1'b0}}, r_first[SEQ_BITS-1:0]};
    assign w_out_low  = (r_count != '0) ? w_low_ext[FIELD_W-1:0] : '0;
    assign w_out_high = (r_count != '0) ? w_high_ext[FIELD_W-1:0] : '0;

    srrt_cmp #(
        .SEQ_BITS (SEQ_BITS)
    ) u_cmp (
        .i_seq   (r_seq),
        .i_entry (mem_rd_data),
        .o_res   (w_cmp)
    );

    srrt_mem #(
        .DEPTH (MAX_RANGES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq        <= n_seq;
        r_pkt        <= n_pkt;
        r_idx        <= n_idx;
        r_shift      <= n_shift;
        r_prev       <= n_prev;
        r_prev_adj   <= n_prev_adj;
        r_cur        <= n_cur;
        r_cur_adj    <= n_cur_adj;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
    end

    // shadow of entry 0 for the result
    always_ff @(posedge i_clk) begin
        if (mem_wr_en && (mem_wr_addr == '0)) begin
            r_first <= mem_wr_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_seq        = r_seq;
        n_pkt        = r_pkt;
        n_idx        = r_idx;
        n_count      = r_count;
        n_shift      = r_shift;
        n_total      = r_total;
        n_prev       = r_prev;
        n_prev_adj   = r_prev_adj;
        n_cur        = r_cur;
        n_cur_adj    = r_cur_adj;
        n_status     = r_status;
        n_out_valid  = r_out_valid & ~i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = '0;
        mem_wr_data  = '0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_seq    = w_seq;
                    n_pkt    = w_pkt;
                    n_idx    = '0;
                    n_status = STAT_OK;
                    if (i_s_axis_tuser[0]) begin
                        n_count = '0;
                        n_total = '0;
                    end
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (r_idx == r_count) begin
                    n_state = ST_DECIDE;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_idx[AW-1:0];
                    n_state     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (w_cmp.dup) begin
                    n_status = STAT_DUP;
                    n_state  = ST_FIN;
                end else if (w_cmp.above) begin
                    n_prev     = mem_rd_data;
                    n_prev_adj = w_cmp.adj_below;
                    n_idx      = r_idx + IW'(1);
                    n_state    = ST_RD;
                end else begin
                    n_cur     = mem_rd_data;
                    n_cur_adj = w_cmp.adj_above;
                    n_state   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_have_prev && r_prev_adj) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = w_idx_m1[AW-1:0];
                    if (w_have_cur && r_cur_adj) begin
                        // gap closed: join with the next range
                        mem_wr_data = {r_prev[EW-1:SEQ_BITS], r_cur[SEQ_BITS-1:0]};
                        n_shift     = r_idx;
                        n_state     = ST_SHDN_RD;
                    end else begin
                        mem_wr_data = {r_prev[EW-1:SEQ_BITS], r_seq};
                        n_state     = ST_FIN;
                    end
                end else if (w_have_cur && r_cur_adj) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx[AW-1:0];
                    mem_wr_data = {r_seq, r_cur[SEQ_BITS-1:0]};
                    n_state     = ST_FIN;
                end else if (r_count == MAX_CNT) begin
                    n_status = STAT_FULL;
                    n_state  = ST_FIN;
                end else begin
                    n_shift = r_count;
                    n_state = ST_SHUP_RD;
                end
            end
            ST_SHUP_RD: begin
                if (r_shift == r_idx) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_idx[AW-1:0];
                    mem_wr_data = {r_seq, r_seq};
                    n_count     = r_count + IW'(1);
                    n_state     = ST_FIN;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = w_shift_m1[AW-1:0];
                    n_state     = ST_SHUP_WR;
                end
            end
            ST_SHUP_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_shift[AW-1:0];
                mem_wr_data = mem_rd_data;
                n_shift     = w_shift_m1;
                n_state     = ST_SHUP_RD;
            end
            ST_SHDN_RD: begin
                if (w_shift_p1 == r_count) begin
                    n_count = r_count - IW'(1);
                    n_state = ST_FIN;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = w_shift_p1[AW-1:0];
                    n_state     = ST_SHDN_WR;
                end
            end
            ST_SHDN_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_shift[AW-1:0];
                mem_wr_data = mem_rd_data;
                n_shift     = w_shift_p1;
                n_state     = ST_SHDN_RD;
            end
            ST_FIN: begin
                if (r_status == STAT_OK) begin
                    n_total = w_total_sat;
                end else begin
                    n_count = '0;
                    n_total = '0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_data   = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, w_out_high, w_out_low,
                                    w_cnt_ext[CNT_OUT_W-1:0], r_total};
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

// ===== src/srrt_checker.sv =====
`include "sequence_range_reorder_tracker_assert.svh"

module srrt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [srrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]                      o_m_axis_tuser
);
    import srrt_pkg::*;

    `SRRT_AST_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result changed under stall")
    `SRRT_AST_NXT(a_busy_after_take, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready straight after a transfer")
    `SRRT_AST_IMP(a_err_clears, o_m_axis_tvalid && (o_m_axis_tuser != STAT_OK), o_m_axis_tdata[OUT_USED_W-1:0] == '0, "error result not cleared")
    `SRRT_AST_IMP(a_status_code, o_m_axis_tvalid, (o_m_axis_tuser == STAT_OK) || (o_m_axis_tuser == STAT_DUP) || (o_m_axis_tuser == STAT_FULL), "unknown status")

endmodule

bind sequence_range_reorder_tracker srrt_checker u_srrt_checker (.*);

// ===== test/sequence_range_reorder_tracker_checker.sv =====
module sequence_range_reorder_tracker_checker
    import srrt_pkg::*;
#(
    parameter int MAX_RANGES = DEF_MAX_RANGES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // sequence_number, first_entry_bytes, rest_bytes, header_offset
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // action
    input  logic [0:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // bytes_received, range_count, first_range_low, first_range_high
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    // status
    input  logic [1:0]            i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [31:0] bytes;
        logic [4:0]  count;
        logic [15:0] low;
        logic [15:0] high;
    } range_report_t;

    logic [15:0]   rng_lo [MAX_RANGES];
    logic [15:0]   rng_hi [MAX_RANGES];
    int unsigned   rng_cnt;
    logic [31:0]   pay_bytes;
    range_report_t expected_reports [$];
    int            errors;

    function automatic void clear_payload();
        rng_cnt   = 0;
        pay_bytes = '0;
    endfunction

    function automatic bit open_range(input int unsigned pos, input logic [15:0] seq);
        int unsigned j;
        if (rng_cnt >= MAX_RANGES || pos > rng_cnt)
            return 1'b0;
        for (j = rng_cnt; j > pos; j--) begin
            rng_lo[j] = rng_lo[j-1];
            rng_hi[j] = rng_hi[j-1];
        end
        rng_lo[pos] = seq;
        rng_hi[pos] = seq;
        rng_cnt++;
        return 1'b1;
    endfunction

    function automatic void join_next(input int unsigned pos);
        int unsigned j;
        if (pos + 1 >= rng_cnt)
            return;
        rng_hi[pos] = rng_hi[pos+1];
        for (j = pos + 1; j + 1 < rng_cnt; j++) begin
            rng_lo[j] = rng_lo[j+1];
            rng_hi[j] = rng_hi[j+1];
        end
        rng_cnt--;
    endfunction

    function automatic t_status place_seq(input logic [15:0] seq);
        int unsigned i;
        logic [16:0] nxt;
        i   = 0;
        nxt = {1'b0, seq} + 17'd1;
        while (i < rng_cnt) begin
            if (seq >= rng_lo[i] && seq <= rng_hi[i])
                return STAT_DUP;
            if (seq > rng_hi[i])
                i++;
            else
                break;
        end
        if (i == 0) begin
            if (rng_cnt > 0 && nxt == {1'b0, rng_lo[0]}) begin
                rng_lo[0] = seq;
                return STAT_OK;
            end
            if (open_range(0, seq))
                return STAT_OK;
            return STAT_FULL;
        end
        if ({1'b0, seq} == {1'b0, rng_hi[i-1]} + 17'd1) begin
            rng_hi[i-1] = seq;
            if (i < rng_cnt && {1'b0, rng_lo[i]} == nxt)
                join_next(i - 1);
            return STAT_OK;
        end
        if (i < rng_cnt && nxt == {1'b0, rng_lo[i]}) begin
            rng_lo[i] = seq;
            return STAT_OK;
        end
        if (open_range(i, seq))
            return STAT_OK;
        return STAT_FULL;
    endfunction

    function automatic range_report_t track_packet(input logic act, input logic [15:0] seq,
                                                   input logic [15:0] first,
                                                   input logic [15:0] rest,
                                                   input logic [7:0] off);
        range_report_t r;
        logic [15:0]   skip;
        logic [16:0]   pkt_bytes;
        logic [32:0]   sum;
        t_status       st;
        // header offset clamped to the first entry
        skip      = ({8'd0, off} > first) ? first : {8'd0, off};
        pkt_bytes = {1'b0, first - skip} + {1'b0, rest};
        if (act)
            clear_payload();
        st = place_seq(seq);
        if (st == STAT_OK) begin
            sum       = {1'b0, pay_bytes} + {16'd0, pkt_bytes};
            pay_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            clear_payload();
        end
        r.status = st;
        r.bytes  = pay_bytes;
        r.count  = 5'(rng_cnt);
        r.low    = (rng_cnt > 0) ? rng_lo[0] : 16'd0;
        r.high   = (rng_cnt > 0) ? rng_hi[0] : 16'd0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        range_report_t want;
        if (!i_rst_n) begin
            clear_payload();
            expected_reports.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none actual %h",
                             $time, i_m_tdata);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("status", 32'(want.status), 32'(i_m_tuser));
                    check_field("bytes_received", want.bytes, i_m_tdata[31:0]);
                    check_field("range_count", 32'(want.count), 32'(i_m_tdata[36:32]));
                    check_field("first_range_low", 32'(want.low), 32'(i_m_tdata[52:37]));
                    check_field("first_range_high", 32'(want.high), 32'(i_m_tdata[68:53]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_reports.push_back(track_packet(i_s_tuser[0], i_s_tdata[15:0],
                                                        i_s_tdata[31:16], i_s_tdata[47:32],
                                                        i_s_tdata[55:48]));
        end
        o_fail_count <= errors;
        o_pending    <= expected_reports.size();
    end

endmodule

// ===== test/sequence_range_reorder_tracker_tb.sv =====
module sequence_range_reorder_tracker_tb;
    import srrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 360;
    localparam int RUN_LEN      = 20;
    localparam int LIMIT_CYCLES = 500_000;
    localparam int TAIL_CYCLES  = 80;

    logic                  i_clk;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // sequence_number, first_entry_bytes, rest_bytes, header_offset
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // action
    logic [0:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_ready  = 1'b0;
    // bytes_received, range_count, first_range_low, first_range_high
    logic [OUT_DATA_W-1:0] m_tdata;
    // status
    logic [1:0]            m_tuser;
    int                    fail_count;
    int                    pending;
    bit                    gaps_on   = 1'b1;
    bit                    stalls_on = 1'b1;
    int                    stall_left = 0;

    sequence_range_reorder_tracker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    sequence_range_reorder_tracker_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin : rx_ready
        int gap;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (stalls_on) begin
            gap        = pick_gap();
            stall_left <= gap;
            m_ready    <= (gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_pkt(input logic act, input logic [15:0] seq, input logic [15:0] first,
                            input logic [15:0] rest, input logic [7:0] off);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {off, rest, first, seq};
        s_tuser  <= act;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_sized(input logic act, input logic [15:0] seq);
        logic [15:0] first;
        // small first entries make the header clamp bite
        first = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
        send_pkt(act, seq, first, 16'($urandom), 8'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : timeout
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sequence_range_reorder_tracker_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int          sent;
        int          next_drain;
        int          len;
        int          k;
        int          pick;
        logic [15:0] base;
        logic [15:0] span;
        logic [15:0] seq;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, duplicate, sequence edges, merge, new payload, full table
        send_pkt(1'b0, 16'd100, 16'd10, 16'd5, 8'd200);
        send_pkt(1'b0, 16'd100, 16'd300, 16'd7, 8'd20);
        send_pkt(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd0);
        send_pkt(1'b0, 16'd0, 16'd0, 16'd1, 8'hFF);
        send_pkt(1'b0, 16'hFFFE, 16'd255, 16'd0, 8'd255);
        send_pkt(1'b0, 16'd1, 16'h8000, 16'h8000, 8'h80);
        send_pkt(1'b0, 16'd3, 16'd40, 16'd0, 8'd40);
        send_pkt(1'b0, 16'd2, 16'd41, 16'd2, 8'd40);
        send_pkt(1'b1, 16'd50, 16'd60, 16'd6, 8'd8);
        for (k = 1; k < 16; k++)
            send_pkt(1'b0, 16'(50 + 2 * k), 16'(k * 1000), 16'(k), 8'(k));
        send_pkt(1'b0, 16'd82, 16'd1, 16'd1, 8'd0);
        send_pkt(1'b0, 16'd7, 16'h5555, 16'hAAAA, 8'h55);
        drain_results();

        sent       = 0;
        next_drain = 120;
        while (sent < RANDOM_ITEMS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on <= ($urandom_range(0, 3) != 0);
            span      = 16'($urandom_range(2, 40));
            case ($urandom_range(0, 3))
                0:       base = 16'd0;
                1:       base = 16'hFFFF - span;
                default: base = 16'($urandom);
            endcase
            len = $urandom_range(3, 40);
            send_sized(1'b1, 16'(base + 16'($urandom_range(0, span))));
            sent++;
            for (k = 1; k < len; k++) begin
                pick = $urandom_range(0, 99);
                seq  = 16'(base + 16'($urandom_range(0, span)));
                if (pick < 90)
                    send_sized(1'b0, seq);
                else if (pick < 96)
                    send_sized(1'b0, 16'($urandom));
                else
                    send_sized(1'b1, 16'($urandom));
                sent++;
            end
            if (sent >= next_drain) begin
                drain_results();
                next_drain += 120;
            end
        end

        // contiguous run of full-size packets growing one range, then a duplicate
        gaps_on   = 1'b0;
        stalls_on <= 1'b0;
        send_pkt(1'b1, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0);
        for (k = 1; k <= RUN_LEN; k++)
            send_pkt(1'b0, 16'(k), 16'hFFFF, 16'hFFFF, 8'd0);
        send_pkt(1'b0, 16'd0, 16'd1, 16'd1, 8'd0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("sequence_range_reorder_tracker_tb: clean");
        else
            $display("sequence_range_reorder_tracker_tb: errors");
        $finish;
    end

endmodule
